// ===== rtl/core/stair_climb_way_counter_macros.svh =====
// Assertion helpers for the stair climb way counter.
`ifndef STAIR_CLIMB_WAY_COUNTER_MACROS_SVH
`define STAIR_CLIMB_WAY_COUNTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SCW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SCW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/scw_pkg.sv =====
package scw_pkg;

    localparam int K_MAX_DEF  = 32;
    localparam int N_MAX_DEF  = 1023;
    localparam int WIDTH_DEF  = 64;

    localparam int STAIR_W    = 10;  // stair_count field width
    localparam int STEP_W     = 6;   // max_step register width
    localparam int STAIR_TD_W = 16;  // stair_count padded to bytes

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(2);

endpackage

// ===== rtl/core/scw_ram.sv =====
module scw_ram #(
    parameter int DW    = 64,
    parameter int DEPTH = 33,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/stair_climb_way_counter.sv =====
// Stair climb way counter.
// Input stream (s_*): one transfer carries a stair count n in s_tdata.
// Output stream (m_*): one transfer per input carries the number of ways to
// climb n stairs with moves of 1..k stairs, modulo 2^WIDTH.
// Configuration: cfg_we / cfg_wdata write k (max_step); 0 acts as 1, values
// above K_MAX act as K_MAX. Write only while the block is idle.
// Operation: n above N_MAX is clamped. n of 0 or 1 answers 1 at once.
// Otherwise the walk seeds window entries 0 and 1, then computes one stair
// per cycle from 2 to n, reading the k-back entry from a window RAM read
// issued the cycle before and keeping the previous value in a register.
// One stair count is walked at a time; s_tready is high only while idle,
// so a new stair count is taken only once the last result has left the
// done state for the output register.
// The RAM read/write port pair sets the one-stair-per-cycle walk.
// Stall: a finished result waits in the output register; a second result
// holds in the done state until the output register frees up.
// Reset: control clears, max_step returns to 2; window contents stay
// undefined, every walk writes entries before reading them.
`include "stair_climb_way_counter_macros.svh"

module stair_climb_way_counter
    import scw_pkg::*;
#(
    parameter int K_MAX = K_MAX_DEF,
    parameter int N_MAX = N_MAX_DEF,
    parameter int WIDTH = WIDTH_DEF,
    localparam int OUT_TD_W = ((WIDTH + 7) / 8) * 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [STAIR_TD_W-1:0] s_tdata,   // [9:0] stair_count
    // output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_TD_W-1:0]   m_tdata,   // [WIDTH-1:0] ways
    // configuration
    input  logic                  cfg_we,
    input  logic [STEP_W-1:0]     cfg_wdata  // max_step
);

    localparam int DEPTH   = K_MAX + 1;
    localparam int AW      = $clog2(DEPTH);
    localparam int WR_INIT = 2 % DEPTH;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_INIT0 = 3'd1;
    localparam logic [2:0] ST_INIT1 = 3'd2;
    localparam logic [2:0] ST_WALK  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [STEP_W-1:0]  max_step_reg, max_step_next;
    logic [STAIR_W-1:0] n_reg, n_next;
    logic [STAIR_W-1:0] step_reg, step_next;
    logic [AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [WIDTH-1:0]   prev_reg, prev_next;
    logic [WIDTH-1:0]   out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic [STEP_W-1:0]  k_eff;
    logic [STAIR_W-1:0] n_in;
    logic [AW-1:0]      rd_init;
    logic               in_xfer;
    logic               out_free;
    logic               sub_en;
    logic [WIDTH-1:0]   step_val;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [WIDTH-1:0]   ram_wdata;
    logic [WIDTH-1:0]   ram_rdata;

    scw_ram #(
        .DW    (WIDTH),
        .DEPTH (DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    // effective stride, clamped to 1..K_MAX
    always_comb
    begin
        k_eff = max_step_reg;
        if (max_step_reg == '0)
        begin
            k_eff = STEP_W'(1);
        end
        else if (int'(max_step_reg) > K_MAX)
        begin
            k_eff = STEP_W'(K_MAX);
        end
    end

    // first subtract address (1 - k) mod DEPTH
    assign rd_init = (k_eff == STEP_W'(1)) ? '0 : AW'(DEPTH + 1 - int'(k_eff));

    assign n_in = (int'(s_tdata[STAIR_W-1:0]) > N_MAX) ? STAIR_W'(N_MAX)
                                                         : s_tdata[STAIR_W-1:0];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // recurrence: 2*prev minus the k-back value once it exists
    assign sub_en   = (step_reg > STAIR_W'(k_eff));
    assign step_val = {prev_reg[WIDTH-2:0], 1'b0} - (sub_en ? ram_rdata : '0);

    always_comb
    begin
        state_next     = state_reg;
        max_step_next  = cfg_we ? cfg_wdata : max_step_reg;
        n_next         = n_reg;
        step_next      = step_reg;
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        prev_next      = prev_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        ram_we         = 1'b0;
        ram_waddr      = wr_ptr_reg;
        ram_wdata      = step_val;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    n_next      = n_in;
                    wr_ptr_next = AW'(WR_INIT);
                    rd_ptr_next = rd_init;
                    prev_next   = WIDTH'(1);
                    state_next  = (n_in <= STAIR_W'(1)) ? ST_DONE : ST_INIT0;
                end
            end
            ST_INIT0:
            begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = WIDTH'(1);
                state_next = ST_INIT1;
            end
            ST_INIT1:
            begin
                // seed entry 1, issue the read for stair 2
                ram_we      = 1'b1;
                ram_waddr   = AW'(1);
                ram_wdata   = WIDTH'(1);
                step_next   = STAIR_W'(2);
                rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
                state_next  = ST_WALK;
            end
            ST_WALK:
            begin
                ram_we      = 1'b1;
                prev_next   = step_val;
                wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
                rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
                if (step_reg == n_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    step_next = step_reg + STAIR_W'(1);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_next       = prev_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            max_step_reg  <= STEP_RESET;
            step_reg      <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            max_step_reg  <= max_step_next;
            step_reg      <= step_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        prev_reg <= prev_next;
        out_reg  <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TD_W'(out_reg);

    `SCW_ASSERT_NOW(a_no_rw_collide, state_reg == ST_WALK, ram_waddr != rd_ptr_reg,
        "window write and read hit the same entry")
    `SCW_ASSERT_NOW(a_step_range, state_reg == ST_WALK,
        step_reg >= STAIR_W'(2) && step_reg <= n_reg, "walk stair out of range")
    `SCW_ASSERT_NOW(a_ptr_range, 1'b1,
        int'(wr_ptr_reg) < DEPTH && int'(rd_ptr_reg) < DEPTH, "window pointer past depth")
    `SCW_ASSERT_NEXT(a_result_shown, state_reg == ST_DONE && out_free,
        m_tvalid && state_reg == ST_IDLE, "finished result not presented")

endmodule

// ===== tb/stair_climb_way_counter_tb.sv =====
`timescale 1ns / 1ps

module stair_climb_way_counter_tb;
    import scw_pkg::*;

    localparam int WIN_DEPTH = K_MAX_DEF + 1;   // circular window depth
    localparam int DRAIN_GAP = 8;               // idle cycles before a cfg write
    localparam int IDLE_PCT  = 37;              // percent of idle cycles per side

    // one expected answer, tagged with the query that produced it
    typedef struct {
        logic [STAIR_W-1:0]   stairs;
        logic [STEP_W-1:0]    stride;
        logic [WIDTH_DEF-1:0] ways;
    } ways_entry_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [STAIR_TD_W-1:0]   s_tdata = '0;       // [9:0] stair_count
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [WIDTH_DEF-1:0]    m_tdata;            // [63:0] ways
    logic                    cfg_we = 1'b0;
    logic [STEP_W-1:0]       cfg_wdata = '0;     // max_step

    // stair counts waiting to be sent, and answers waiting to come back
    logic [STAIR_W-1:0]      stair_q[$];
    ways_entry_t             ways_q[$];

    // testbench copy of max_step; tracks every cfg write
    logic [STEP_W-1:0]       step_setting = STEP_RESET;
    logic                    steady = 1'b0;      // both sides skip idling while set
    int                      error_count = 0;
    int                      query_count = 0;
    int                      answer_count = 0;
    int                      setting_count = 1;  // reset value counts as one
    int                      max_stairs_seen = 0;

    stair_climb_way_counter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Number of ordered move sequences of 1..k stairs reaching stair n, mod 2^64.
    // k of 0 acts as 1 and k above K_MAX acts as K_MAX; n is capped at N_MAX.
    // The walk keeps a circular window of the last K_MAX+1 values, like the block.
    function automatic logic [WIDTH_DEF-1:0] climb_ways(input logic [STAIR_W-1:0] stairs,
                                                        input logic [STEP_W-1:0] stride);
        logic [WIDTH_DEF-1:0] win [0:WIN_DEPTH-1];
        logic [WIDTH_DEF-1:0] nxt;
        int k;
        int n;
        k = int'(stride);
        if (k < 1)
            k = 1;
        if (k > K_MAX_DEF)
            k = K_MAX_DEF;
        n = int'(stairs);
        if (n > N_MAX_DEF)
            n = N_MAX_DEF;
        win[0] = 1;
        win[1] = 1;
        for (int s = 2; s <= n; s++)
        begin
            nxt = win[(s - 1) % WIN_DEPTH] << 1;
            // the k-back term only exists once the walk is past stair k
            if (s >= k + 1)
                nxt = nxt - win[(s - 1 - k) % WIN_DEPTH];
            win[s % WIN_DEPTH] = nxt;
        end
        return (n <= 1) ? WIDTH_DEF'(1) : win[n % WIN_DEPTH];
    endfunction

    // Driver: presents stair counts from stair_q. Valid stays up until the
    // transfer completes; a new item is loaded in the same edge that retires
    // the old one, so tvalid never gets two assignments in one step.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                // predict now, with the stride in force at this transfer
                ways_q.push_back('{s_tdata[STAIR_W-1:0], step_setting,
                                   climb_ways(s_tdata[STAIR_W-1:0], step_setting)});
                query_count++;
                if (int'(s_tdata[STAIR_W-1:0]) > max_stairs_seen)
                    max_stairs_seen = int'(s_tdata[STAIR_W-1:0]);
            end
            if (!s_tvalid || s_tready)
            begin
                if (stair_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= STAIR_TD_W'(stair_q.pop_front());
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random backpressure on m_tready, and every output transfer is
    // checked against the oldest expected answer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                answer_count++;
                if (ways_q.size() == 0)
                begin
                    $display("%0t: unexpected ways transfer, expected none, actual %0d",
                             $time, m_tdata);
                    error_count++;
                end
                else if (m_tdata !== ways_q[0].ways)
                begin
                    $display("%0t: ways mismatch n=%0d k=%0d, expected %0d, actual %0d",
                             $time, ways_q[0].stairs, ways_q[0].stride,
                             ways_q[0].ways, m_tdata);
                    error_count++;
                    void'(ways_q.pop_front());
                end
                else
                begin
                    void'(ways_q.pop_front());
                end
            end
            m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Wait until nothing is queued, nothing is on the input bus and every
    // expected answer has come back.
    task automatic wait_drained();
        while (stair_q.size() != 0 || s_tvalid || ways_q.size() != 0)
            @(posedge clk);
    endtask

    // The register may only change while the block sits idle.
    task automatic write_max_step(input logic [STEP_W-1:0] value);
        wait_drained();
        repeat (DRAIN_GAP) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        step_setting = value;
        setting_count++;
    endtask

    // Mostly short walks; a tenth go long, up to the full 1023 stairs.
    function automatic logic [STAIR_W-1:0] pick_stairs();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return STAIR_W'($urandom_range(40, 0));
        else if (r < 90)
            return STAIR_W'($urandom_range(300, 41));
        return STAIR_W'($urandom_range(1023, 301));
    endfunction

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Reset stride (2): zero and one stair answer 1 with
        // no walk, small counts, the full count.
        stair_q = '{10'd0, 10'd1, 10'd2, 10'd3, 10'd4, 10'd1023};
        // single-stair moves: every count has exactly one way
        write_max_step(6'd1);
        stair_q = '{10'd0, 10'd2, 10'd1023};
        // largest stride: subtraction starts exactly at stair k+1
        write_max_step(6'd32);
        stair_q = '{10'd31, 10'd32, 10'd33, 10'd34, 10'd1023};
        // stride zero acts as one
        write_max_step(6'd0);
        stair_q = '{10'd5, 10'd1023};
        // all ones saturates to K_MAX; also a stride just past the limit
        write_max_step(6'd63);
        stair_q = '{10'd33, 10'd1023};
        write_max_step(6'd33);
        stair_q = '{10'd34, 10'd700};

        // Random part: ten phases of random stride, each with random stairs.
        // One phase runs without idling; in another the sender stops halfway
        // and waits for every answer before going on.
        for (int phase = 0; phase < 10; phase++)
        begin
            write_max_step(STEP_W'($urandom_range(63, 0)));
            steady = (phase == 6);
            for (int i = 0; i < 58; i++)
            begin
                if (phase == 3 && i == 29)
                    wait_drained();
                stair_q.push_back(pick_stairs());
            end
            wait_drained();
            steady = 1'b0;
        end

        wait_drained();
        repeat (20) @(posedge clk);
        $display("Ran %0d stair queries (0 to %0d stairs) under %0d stride settings,",
                 query_count, max_stairs_seen, setting_count);
        $display("including stride 0, 1, 32, 33 and 63; %0d answers checked.",
                 answer_count);
        if (error_count == 0 && ways_q.size() == 0)
            $display("stair_climb_way_counter_tb passed");
        else
            $display("stair_climb_way_counter_tb failed");
        $finish;
    end

    // Hang guard, sized well above the slowest legal run.
    initial
    begin
        #30ms;
        $display("stair_climb_way_counter_tb failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/scw_pkg.sv
rtl/core/scw_ram.sv
rtl/core/stair_climb_way_counter.sv
tb/stair_climb_way_counter_tb.sv
